[rtl/assert_macros.svh]
// Assertion helper macros shared by the checker files.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/hnm_pkg.sv]
// ---------------------------------------------------------------------------
// hnm_pkg
// Types, codes and constants shared by the height-to-normal-map block.
// ---------------------------------------------------------------------------
package hnm_pkg;

    // Default store dimensions.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Coordinates of neighbors may reach map size minus one, up to 510.
    localparam int COORD_W = 9;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BUMP_FACTOR = 2'd2;

    // Function codes of an input item.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Class of a queued command.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_READ    = 4'd1,
        ST_DIFF    = 4'd2,
        ST_SCALE_F = 4'd3,
        ST_SCALE_S = 4'd4,
        ST_SHIFT   = 4'd5,
        ST_SQUARE  = 4'd6,
        ST_CSQ     = 4'd7,
        ST_ASQ     = 4'd8,
        ST_PLO     = 4'd9,
        ST_PHI     = 4'd10,
        ST_CMP     = 4'd11,
        ST_DONE    = 4'd12
    } state_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        kind_t                kind;
        logic [7:0]           x;
        logic [7:0]           y;
        logic [COORD_W-1:0]   xn;
        logic [COORD_W-1:0]   xp;
        logic [COORD_W-1:0]   yn;
        logic [COORD_W-1:0]   yp;
        logic [15:0]          height;
    } hnm_cmd_t;

    // Configuration in effect.
    typedef struct packed {
        logic [8:0]  width;
        logic [8:0]  height;
        logic [15:0] factor;
    } hnm_cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic       err;
    } hnm_res_t;

    // Clamp a map size register value to [2, maxv].
    function automatic logic [8:0] sat_size(input logic [8:0] v, input int maxv);
        logic [8:0] r;
        r = v;
        if (v < 9'd2)
            r = 9'd2;
        else if (int'(v) > maxv)
            r = 9'(maxv);
        return r;
    endfunction

endpackage

[rtl/height_to_normal_map_top.sv]
// A query result's delay after the item's transfer is set by the normalizing shift
// (one bit a cycle) and the 8-step search per component; a write is stored as it is popped.
// The back end runs one command at a time; a query holds it until its result is loaded.
// A two-entry queue and the output register let input and output stall independently.
// Reset clears control state and sets configuration to defaults; height store contents stay undefined.
// ---------------------------------------------------------------------------
// height_to_normal_map_top
// Height map store with central-difference normal lookup, stream interface.
// ---------------------------------------------------------------------------
module height_to_normal_map_top
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // texel_x[7:0], texel_y[15:8], height_value[31:16]
    input  logic        s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // normal_x[7:0], normal_y[15:8], normal_z[23:16]
    output logic        m_axis_tuser,   // coord_error[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RST_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int RST_H = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

    hnm_cfg_t cfg_reg;
    hnm_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_pop;
    hnm_res_t res;

    // Configuration registers; a write transfer is always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 9'(RST_W);
            cfg_reg.height <= 9'(RST_H);
            cfg_reg.factor <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:   cfg_reg.width  <= sat_size(cfg_data[8:0], MAX_WIDTH);
                REG_MAP_HEIGHT:  cfg_reg.height <= sat_size(cfg_data[8:0], MAX_HEIGHT);
                REG_BUMP_FACTOR: cfg_reg.factor <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: classify and queue.
    hnm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_x      (s_axis_tdata[7:0]),
        .in_y      (s_axis_tdata[15:8]),
        .in_height (s_axis_tdata[31:16]),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Back end: store and normal computation.
    hnm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.nz, res.ny, res.nx};
    assign m_axis_tuser = res.err;

endmodule

[rtl/hnm_front.sv]
// ---------------------------------------------------------------------------
// hnm_front
// Accepts input items, checks coordinates, works out the wrapped neighbor
// coordinates and queues the classified command for the back end.
// ---------------------------------------------------------------------------
module hnm_front
    import hnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_func,
    input  logic [7:0]  in_x,
    input  logic [7:0]  in_y,
    input  logic [15:0] in_height,
    input  hnm_cfg_t    cfg,
    output hnm_cmd_t    cmd,
    output logic        cmd_valid,
    input  logic        cmd_pop
);

    hnm_cmd_t   entry;
    hnm_cmd_t   q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       out_range;
    logic [8:0] x9;
    logic [8:0] y9;

    // Classify the incoming item.
    assign x9        = {1'b0, in_x};
    assign y9        = {1'b0, in_y};
    assign out_range = (x9 >= cfg.width) || (y9 >= cfg.height);

    always_comb
    begin
        entry.x      = in_x;
        entry.y      = in_y;
        entry.height = in_height;
        entry.xn     = ((x9 + 9'd1) < cfg.width) ? (x9 + 9'd1) : 9'd0;
        entry.xp     = (in_x != 8'd0) ? (x9 - 9'd1) : (cfg.width - 9'd1);
        entry.yn     = ((y9 + 9'd1) < cfg.height) ? (y9 + 9'd1) : 9'd0;
        entry.yp     = (in_y != 8'd0) ? (y9 - 9'd1) : (cfg.height - 9'd1);
        if (out_range)
            entry.kind = KIND_ERROR;
        else if (in_func == FUNC_QUERY)
            entry.kind = KIND_QUERY;
        else
            entry.kind = KIND_WRITE;
    end

    // Two-entry command queue.
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
            count_next = count_reg + 2'd1;
        else if (!push && cmd_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= ~wptr_reg;
            if (cmd_pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= entry;
    end

endmodule

[rtl/hnm_back.sv]
// ---------------------------------------------------------------------------
// hnm_back
// Holds the height store and carries out commands: stores heights, reads
// the four neighbors of a query, scales the differences and finds each
// normal component by a bitwise search.
// ---------------------------------------------------------------------------
module hnm_back
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  hnm_cfg_t cfg,
    input  hnm_cmd_t cmd,
    input  logic     cmd_valid,
    output logic     cmd_pop,
    output logic     res_valid,
    input  logic     res_ready,
    output hnm_res_t res
);

    localparam int          DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int          AW         = $clog2(DEPTH);
    localparam logic [31:0] ROW_STRIDE = 32'(MAX_WIDTH);

    state_t      state_reg;
    state_t      state_next;

    // Store and its port.
    logic [15:0]        mem_array [DEPTH];
    logic [15:0]        rd_data_reg;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [COORD_W-1:0] addr_x;
    logic [COORD_W-1:0] addr_y;

    // Sequencer data.
    hnm_cmd_t    cmd_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  kres_reg;
    logic [15:0] h_reg [4];
    logic [15:0] absdx_reg;
    logic [15:0] absdy_reg;
    logic        posx_reg;
    logic        posy_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [40:0] mx_reg;
    logic [40:0] my_reg;
    logic [25:0] mz_reg;
    logic [45:0] l2_reg;
    logic [59:0] c2_reg;
    logic [15:0] a2_reg;
    logic [38:0] plo_reg;
    logic [38:0] phi_reg;
    logic [7:0]  k_reg [3];
    logic        err_reg;

    // Output register.
    logic        res_valid_reg;
    hnm_res_t    res_reg;
    logic        load_res;

    // Combinational helpers.
    logic [16:0] dx;
    logic [16:0] dy;
    logic        too_big;
    logic [21:0] msel;
    logic [21:0] mcomp;
    logic        neg;
    logic [7:0]  trial;
    logic [8:0]  amag;
    logic [61:0] prod;
    logic        upper;
    logic        pass;
    logic [29:0] cm;

    // Neighbor differences.
    assign dx = {1'b0, h_reg[0]} - {1'b0, h_reg[1]};
    assign dy = {1'b0, h_reg[2]} - {1'b0, h_reg[3]};

    // Normalizing shift continues while any magnitude reaches 2^22.
    assign too_big = (|mx_reg[40:22]) || (|my_reg[40:22]) || (|mz_reg[25:22]);

    // Magnitude selected by the square counter and by the component.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    msel = mx_reg[21:0];
            2'd1:    msel = my_reg[21:0];
            default: msel = mz_reg[21:0];
        endcase
        case (comp_reg)
            2'd0:
            begin
                mcomp = mx_reg[21:0];
                neg   = posx_reg && (mx_reg[21:0] != 22'd0);
            end
            2'd1:
            begin
                mcomp = my_reg[21:0];
                neg   = posy_reg && (my_reg[21:0] != 22'd0);
            end
            default:
            begin
                mcomp = mz_reg[21:0];
                neg   = 1'b0;
            end
        endcase
    end

    assign cm = {mcomp, 8'd0} - {8'd0, mcomp};

    // Trial code of the search and the test on it.
    assign trial = kres_reg | (8'd1 << bit_reg);
    assign amag  = (trial >= 8'd128) ? ({trial, 1'b0} - 9'd256) : (9'd256 - {trial, 1'b0});
    assign upper = (trial > 8'd128);
    assign prod  = {phi_reg, 23'd0} + {23'd0, plo_reg};
    assign pass  = neg ? (!upper && (prod >= {2'd0, c2_reg}))
                       : (!upper || (prod <= {2'd0, c2_reg}));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        KIND_QUERY: state_next = ST_READ;
                        KIND_ERROR: state_next = ST_DONE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:    if (cnt_reg == 3'd4) state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_SCALE_F;
            ST_SCALE_F: state_next = ST_SCALE_S;
            ST_SCALE_S: state_next = ST_SHIFT;
            ST_SHIFT:   if (!too_big) state_next = ST_SQUARE;
            ST_SQUARE:  if (cnt_reg == 3'd2) state_next = ST_CSQ;
            ST_CSQ:     state_next = ST_ASQ;
            ST_ASQ:     state_next = ST_PLO;
            ST_PLO:     state_next = ST_PHI;
            ST_PHI:     state_next = ST_CMP;
            ST_CMP:
            begin
                if (bit_reg != 3'd0)
                    state_next = ST_ASQ;
                else if (comp_reg == 2'd2)
                    state_next = ST_DONE;
                else
                    state_next = ST_CSQ;
            end
            ST_DONE:    if (load_res) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
        mem_we   = cmd_pop && (cmd.kind == KIND_WRITE);
        load_res = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);
        addr_x   = {1'b0, cmd.x};
        addr_y   = {1'b0, cmd.y};
        if (state_reg == ST_READ)
        begin
            case (cnt_reg[1:0])
                2'd0:
                begin
                    addr_x = cmd_reg.xn;
                    addr_y = {1'b0, cmd_reg.y};
                end
                2'd1:
                begin
                    addr_x = cmd_reg.xp;
                    addr_y = {1'b0, cmd_reg.y};
                end
                2'd2:
                begin
                    addr_x = {1'b0, cmd_reg.x};
                    addr_y = cmd_reg.yn;
                end
                default:
                begin
                    addr_x = {1'b0, cmd_reg.x};
                    addr_y = cmd_reg.yp;
                end
            endcase
        end
    end

    assign mem_addr = AW'(32'(addr_y) * ROW_STRIDE + 32'(addr_x));

    // Height store, single port with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_array[mem_addr] <= cmd.height;
        rd_data_reg <= mem_array[mem_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= cmd;
                cnt_reg <= 3'd0;
                err_reg <= (cmd.kind == KIND_ERROR);
            end
            ST_READ:
            begin
                if (cnt_reg != 3'd0)
                    h_reg[2'(cnt_reg - 3'd1)] <= rd_data_reg;
                cnt_reg <= cnt_reg + 3'd1;
            end
            ST_DIFF:
            begin
                absdx_reg <= dx[16] ? 16'(-dx) : dx[15:0];
                absdy_reg <= dy[16] ? 16'(-dy) : dy[15:0];
                posx_reg  <= !dx[16] && (dx != 17'd0);
                posy_reg  <= !dy[16] && (dy != 17'd0);
            end
            ST_SCALE_F:
            begin
                px_reg <= absdx_reg * cfg.factor;
                py_reg <= absdy_reg * cfg.factor;
            end
            ST_SCALE_S:
            begin
                mx_reg <= px_reg * cfg.width;
                my_reg <= py_reg * cfg.height;
                mz_reg <= 26'd1 << 25;
            end
            ST_SHIFT:
            begin
                if (too_big)
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                    mz_reg <= mz_reg >> 1;
                end
                l2_reg  <= 46'd0;
                cnt_reg <= 3'd0;
            end
            ST_SQUARE:
            begin
                l2_reg   <= l2_reg + (46'(msel) * 46'(msel));
                cnt_reg  <= cnt_reg + 3'd1;
                comp_reg <= 2'd0;
            end
            ST_CSQ:
            begin
                c2_reg   <= 60'(cm) * 60'(cm);
                kres_reg <= 8'd0;
                bit_reg  <= 3'd7;
            end
            ST_ASQ:
            begin
                a2_reg <= 16'(amag * amag);
            end
            ST_PLO:
            begin
                plo_reg <= 39'(a2_reg) * 39'(l2_reg[22:0]);
            end
            ST_PHI:
            begin
                phi_reg <= 39'(a2_reg) * 39'(l2_reg[45:23]);
            end
            ST_CMP:
            begin
                if (pass)
                    kres_reg <= trial;
                if (bit_reg == 3'd0)
                begin
                    k_reg[comp_reg] <= pass ? trial : kres_reg;
                    comp_reg        <= comp_reg + 2'd1;
                end
                else
                    bit_reg <= bit_reg - 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Result register; an error result carries zero normals.
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg.err <= err_reg;
            res_reg.nx  <= err_reg ? 8'd0 : k_reg[0];
            res_reg.ny  <= err_reg ? 8'd0 : k_reg[1];
            res_reg.nz  <= err_reg ? 8'd0 : k_reg[2];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[rtl/hnm_checker.sv]
// ---------------------------------------------------------------------------
// hnm_checker
// Port-level checks on the result stream of the normal map block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hnm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled result stays offered.
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A stalled result keeps its payload.
    `ASSERT_NEXT(a_hold_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An error result carries zero normals.
    `ASSERT_IMPLY(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0)

    // The z component of a normal never points down.
    `ASSERT_IMPLY(a_z_up, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:16] >= 8'd128)

endmodule

bind height_to_normal_map_top hnm_checker u_hnm_checker (.*);

[sim/tb_height_to_normal_map_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_height_to_normal_map_top
// Self-checking bench for the height-to-normal-map block. Heights are written
// around each queried texel before the query, so only stored texels are read.
// Results are predicted in a scoreboard class. The bench steps through several
// map sizes and bump factors, the extremes among them. Both stream sides idle
// at random, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_height_to_normal_map_top;
    import hnm_pkg::*;

    // Index past the register list; the block must ignore it.
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int TIMEOUT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES   = 200;

    // Predicts normals from its own copy of the height store and registers.
    class normal_scoreboard;
        hnm_res_t        pending[$];
        logic [15:0]     heights[65536];
        int unsigned     map_w;
        int unsigned     map_h;
        int unsigned     bump;
        int              errors;

        function new();
            map_w  = 256;
            map_h  = 256;
            bump   = 256;
            errors = 0;
        endfunction

        function int unsigned clamp_size(logic [15:0] v);
            int unsigned s;
            s = v[8:0];
            if (s < 2) return 2;
            if (s > 256) return 256;
            return s;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_MAP_WIDTH)
                map_w = clamp_size(v);
            else if (idx == REG_MAP_HEIGHT)
                map_h = clamp_size(v);
            else if (idx == REG_BUMP_FACTOR)
                bump = v;
        endfunction

        // Largest code k with (2k-256)*sqrt(len2) <= 255*c, evaluated exactly.
        function logic [7:0] to_code(longint unsigned mag, bit neg, longint unsigned len2);
            longint unsigned cm, c2, am, lhs;
            int a;
            cm = 255 * mag;
            c2 = cm * cm;
            for (int k = 255; k >= 1; k--)
            begin
                a   = 2 * k - 256;
                am  = (a < 0) ? -a : a;
                lhs = am * am * len2;
                if (a > 0)
                begin
                    if (!neg && lhs <= c2) return k[7:0];
                end
                else
                begin
                    if (!neg) return k[7:0];
                    if (lhs >= c2) return k[7:0];
                end
            end
            return 8'd0;
        endfunction

        function void note_input(logic func, logic [7:0] x, logic [7:0] y, logic [15:0] hv);
            int unsigned xn, xp, yn, yp;
            int dx, dy;
            longint unsigned mx, my, mz, len2;
            hnm_res_t r;
            if (x >= map_w || y >= map_h)
            begin
                r = '{nx: 8'd0, ny: 8'd0, nz: 8'd0, err: 1'b1};
                pending.push_back(r);
                return;
            end
            if (func == FUNC_WRITE)
            begin
                heights[{y, x}] = hv;
                return;
            end
            xn = (x + 1 < map_w) ? x + 1 : 0;
            xp = (x > 0) ? x - 1 : map_w - 1;
            yn = (y + 1 < map_h) ? y + 1 : 0;
            yp = (y > 0) ? y - 1 : map_h - 1;
            dx = int'(heights[y * 256 + xn]) - int'(heights[y * 256 + xp]);
            dy = int'(heights[yn * 256 + x]) - int'(heights[yp * 256 + x]);
            mx = longint'(dx < 0 ? -dx : dx) * bump * map_w;
            my = longint'(dy < 0 ? -dy : dy) * bump * map_h;
            mz = 64'd1 << 25;
            // Scale the vector down together until every magnitude fits 22 bits.
            while (mx >= (64'd1 << 22) || my >= (64'd1 << 22) || mz >= (64'd1 << 22))
            begin
                mx = mx >> 1;
                my = my >> 1;
                mz = mz >> 1;
            end
            len2 = mx * mx + my * my + mz * mz;
            r.nx  = to_code(mx, dx > 0 && mx > 0, len2);
            r.ny  = to_code(my, dy > 0 && my > 0, len2);
            r.nz  = to_code(mz, 1'b0, len2);
            r.err = 1'b0;
            pending.push_back(r);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] d, logic u);
            hnm_res_t r;
            if (pending.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %h/%b", $time, d, u);
                errors++;
                return;
            end
            r = pending.pop_front();
            compare("normal_x", r.nx, d[7:0]);
            compare("normal_y", r.ny, d[15:8]);
            compare("normal_z", r.nz, d[23:16]);
            compare("coord_error", r.err, u);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    normal_scoreboard normals = new();
    bit          stored[65536];
    int          hold_off_cycles = 0;
    bit          steady = 1'b0;
    int          cycle_count = 0;
    int unsigned cur_w = 256;
    int unsigned cur_h = 256;

    height_to_normal_map_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one, none in steady stretches.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: check each transfer, then choose the next ready level.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                normals.check_result(m_axis_tdata, m_axis_tuser);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles = hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
            begin
                if ($urandom_range(0, 299) == 0)
                    hold_off_cycles = $urandom_range(20, 150);
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    function automatic logic [15:0] pick_height();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // One input transfer, then a random pause.
    task automatic send_item(logic func, logic [7:0] x, logic [7:0] y, logic [15:0] hv);
        int n;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {hv, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        normals.note_input(func, x, y, hv);
        if (func == FUNC_WRITE && x < cur_w && y < cur_h)
            stored[{y, x}] = 1'b1;
        n = pause_len();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (normals.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        normals.set_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_map(logic [15:0] w, logic [15:0] h, logic [15:0] f);
        wait_idle();
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_BUMP_FACTOR, f);
        cur_w = normals.map_w;
        cur_h = normals.map_h;
    endtask

    // Store a height at (x,y) unless one is there already.
    task automatic fill(int unsigned x, int unsigned y);
        if (!stored[y * 256 + x])
            send_item(FUNC_WRITE, x[7:0], y[7:0], pick_height());
    endtask

    // Query a texel after making sure its four neighbors hold heights.
    task automatic query_at(int unsigned x, int unsigned y);
        fill((x + 1 < cur_w) ? x + 1 : 0, y);
        fill((x > 0) ? x - 1 : cur_w - 1, y);
        fill(x, (y + 1 < cur_h) ? y + 1 : 0);
        fill(x, (y > 0) ? y - 1 : cur_h - 1);
        send_item(FUNC_QUERY, x[7:0], y[7:0], 16'($urandom_range(0, 65535)));
    endtask

    // Random mix: mostly queries with their neighborhoods, some writes and misses.
    task automatic random_items(int count);
        int r;
        int unsigned x, y;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) == 0)
                steady = ~steady;
            r = $urandom_range(0, 99);
            x = $urandom_range(0, cur_w - 1);
            y = $urandom_range(0, cur_h - 1);
            if (r < 10 && (cur_w < 256 || cur_h < 256))
            begin
                if (cur_w < 256 && (cur_h == 256 || $urandom_range(0, 1)))
                    x = $urandom_range(cur_w, 255);
                else
                    y = $urandom_range(cur_h, 255);
                send_item(1'($urandom_range(0, 1)), x[7:0], y[7:0], pick_height());
            end
            else if (r < 35)
                send_item(FUNC_WRITE, x[7:0], y[7:0], pick_height());
            else
                query_at(x, y);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: steepest slopes at the wrapping corners of the full map.
        send_item(FUNC_WRITE, 8'd1, 8'd0, 16'hFFFF);
        send_item(FUNC_WRITE, 8'd255, 8'd0, 16'h0000);
        send_item(FUNC_WRITE, 8'd0, 8'd1, 16'h0000);
        send_item(FUNC_WRITE, 8'd0, 8'd255, 16'hFFFF);
        send_item(FUNC_QUERY, 8'd0, 8'd0, 16'hFFFF);
        send_item(FUNC_WRITE, 8'd0, 8'd0, 16'h8000);
        send_item(FUNC_WRITE, 8'd254, 8'd255, 16'hFFFF);
        send_item(FUNC_WRITE, 8'd255, 8'd254, 16'h0001);
        send_item(FUNC_WRITE, 8'd255, 8'd0, 16'hFFFF);
        send_item(FUNC_QUERY, 8'd255, 8'd255, 16'h0000);
        query_at(128, 127);
        query_at(255, 255);

        // Full map at maximum factor, with one long result-side stall.
        set_map(16'd256, 16'd256, 16'hFFFF);
        write_reg(REG_NONE, 16'hFFFF);
        hold_off_cycles = 3000;
        random_items(80);

        // Smallest map, flat factor; out-of-range writes and queries.
        set_map(16'd2, 16'd2, 16'd0);
        send_item(FUNC_WRITE, 8'd2, 8'd0, 16'h1234);
        send_item(FUNC_QUERY, 8'd0, 8'd255, 16'h0000);
        send_item(FUNC_WRITE, 8'd255, 8'd255, 16'hFFFF);
        random_items(70);

        // Register values below and above the legal range.
        set_map(16'd1, 16'hFFFF, 16'd1);
        random_items(90);
        set_map(16'd0, 16'd257, 16'h8000);
        random_items(90);

        set_map(16'd5, 16'd3, 16'd256);
        random_items(90);
        set_map(16'd16, 16'd16, 16'h00FF);
        random_items(90);
        set_map(16'($urandom_range(2, 255)), 16'($urandom_range(2, 255)),
                16'($urandom_range(0, 65535)));
        random_items(80);
        set_map(16'd255, 16'd256, 16'd4);
        random_items(70);

        wait_idle();
        if (normals.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[height_to_normal_map_top.f]
+incdir+rtl
rtl/hnm_pkg.sv
rtl/hnm_front.sv
rtl/hnm_back.sv
rtl/height_to_normal_map_top.sv
rtl/hnm_checker.sv
sim/tb_height_to_normal_map_top.sv
